FILE: hdl/assert_macros.svh
// Assertion macros shared by the burst detector RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bdh_pkg.sv
// Shared types and constants of the hysteresis burst detector.
// No dependencies; used by every module under hdl/.
`default_nettype none

package bdh_pkg;

	localparam int MAX_PINGS  = 128;
	localparam int MAX_RECORD = 65536;

	localparam int LVL_W  = 16;
	localparam int PER_W  = 16;
	localparam int MINW_W = 32;
	localparam int TIME_W = 32;
	localparam int IDX_W  = $clog2(MAX_RECORD);
	localparam int CNT_W  = 8;
	localparam int WID_W  = IDX_W + 1 + PER_W;

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_RECORD - 1);

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_AW-1:0] {
		REG_ON_THR  = 2'd0,
		REG_OFF_THR = 2'd1,
		REG_PERIOD  = 2'd2,
		REG_MIN_W   = 2'd3
	} reg_idx_t;

	localparam logic signed [LVL_W-1:0] ON_THR_RST  = 16'sd1280;
	localparam logic signed [LVL_W-1:0] OFF_THR_RST = 16'sd768;
	localparam logic [PER_W-1:0]        PERIOD_RST  = 16'd1;
	localparam logic [MINW_W-1:0]       MIN_W_RST   = 32'd2;

	typedef enum logic {
		KIND_BURST   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] on_thr;
		logic signed [LVL_W-1:0] off_thr;
		logic [PER_W-1:0]        period;
		logic [MINW_W-1:0]       min_w;
	} cfg_t;

	// One queue entry: what a sample asks the back end to do.
	typedef struct packed {
		logic                    clr;    // record restart, count back to zero
		logic                    cand;   // burst closed, check and maybe report
		logic                    summ;   // last sample, summary beat follows
		logic [IDX_W-1:0]        start;
		logic [IDX_W-1:0]        span;
		logic signed [LVL_W-1:0] peak;
	} evt_t;

endpackage

`default_nettype wire

FILE: hdl/bdh_fifo.sv
// Short flop-based queue between the classifying front and the reporting back.
// Depends on bdh_pkg.
`default_nettype none

module bdh_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bdh_pkg::evt_t wr_evt,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output bdh_pkg::evt_t      rd_evt
);

	bdh_pkg::evt_t                  mem_q [bdh_pkg::QDEPTH];
	logic [bdh_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bdh_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bdh_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (count_q == bdh_pkg::QCNT_W'(bdh_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_evt  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == bdh_pkg::QPTR_W'(bdh_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == bdh_pkg::QPTR_W'(bdh_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_evt;
	end

	`include "assert_macros.svh"

	`ASSERT_RST(a_push_not_full, push |-> !full, "bdh_fifo: push while full")
	`ASSERT_RST(a_count_bound, count_q <= bdh_pkg::QCNT_W'(bdh_pkg::QDEPTH), "bdh_fifo: count overrun")

endmodule

`default_nettype wire

FILE: hdl/bdh_front.sv
// Front end: accepts level samples, tracks the hysteresis state and sample index,
// and queues an entry whenever a burst closes or a record starts or ends. Uses bdh_pkg.
`default_nettype none

module bdh_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bdh_pkg::cfg_t          cfg,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [bdh_pkg::LVL_W-1:0] level,
	input  wire logic                   first_sample,
	input  wire logic                   last_sample,
	input  wire logic                   q_full,
	output logic                        push,
	output bdh_pkg::evt_t               evt
);

	logic                             in_burst_q;
	logic [bdh_pkg::IDX_W-1:0]        idx_q;
	logic [bdh_pkg::IDX_W-1:0]        start_q;
	logic signed [bdh_pkg::LVL_W-1:0] peak_q;

	logic                             accept;
	logic signed [bdh_pkg::LVL_W-1:0] lvl;
	logic [bdh_pkg::IDX_W-1:0]        idx_n;
	logic                             opening;
	logic                             open_now;
	logic [bdh_pkg::IDX_W-1:0]        start_n;
	logic signed [bdh_pkg::LVL_W-1:0] peak_base;
	logic signed [bdh_pkg::LVL_W-1:0] peak_n;
	logic                             closing;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign lvl      = $signed(level);

	always_comb begin
		idx_n     = (idx_q != bdh_pkg::IDX_MAX) ? idx_q + 1'b1 : idx_q;
		opening   = !in_burst_q && (lvl >= $signed(cfg.on_thr));
		open_now  = in_burst_q || opening;
		start_n   = opening ? idx_n : start_q;
		peak_base = opening ? '0 : peak_q;
		peak_n    = (lvl > peak_base) ? lvl : peak_base;
		closing   = open_now && ((lvl < $signed(cfg.off_thr)) || last_sample);

		evt.clr   = first_sample;
		evt.cand  = !first_sample && closing;
		evt.summ  = last_sample;
		evt.start = start_n;
		evt.span  = idx_n - start_n;
		evt.peak  = peak_n;
		push      = accept && (evt.clr || evt.cand || evt.summ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_burst_q <= 1'b0;
			idx_q      <= '0;
			start_q    <= '0;
			peak_q     <= '0;
		end else if (accept) begin
			if (first_sample) begin
				in_burst_q <= 1'b0;
				idx_q      <= '0;
				start_q    <= '0;
				peak_q     <= '0;
			end else begin
				idx_q      <= idx_n;
				start_q    <= start_n;
				in_burst_q <= open_now && !closing;
				if (open_now)
					peak_q <= closing ? '0 : peak_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bdh_back.sv
// Back end: forms start time, duration and width products for a queued entry,
// applies the width and count limits, and drives the registered result beats. Uses bdh_pkg.
`default_nettype none

module bdh_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bdh_pkg::cfg_t              cfg,
	input  wire logic                       q_empty,
	input  wire bdh_pkg::evt_t              q_evt,
	output logic                            pop,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [87:0]                     m_tdata,   // start_time, duration, peak_level, burst_count
	output logic                            m_tuser,   // record_kind
	output logic                            m_tlast    // end_of_run
);

	// product stage
	logic                             s1_valid_q;
	logic                             s1_clr_s1;
	logic                             s1_cand_s1;
	logic                             s1_summ_s1;
	logic [bdh_pkg::TIME_W-1:0]       start_time_s1;
	logic [bdh_pkg::TIME_W-1:0]       duration_s1;
	logic [bdh_pkg::WID_W-1:0]        width_s1;
	logic signed [bdh_pkg::LVL_W-1:0] peak_s1;

	logic                             phase_q;   // burst beat sent, summary still owed
	logic [bdh_pkg::CNT_W-1:0]        seen_q;

	logic                             out_valid_q;
	logic [bdh_pkg::TIME_W-1:0]       out_start_q;
	logic [bdh_pkg::TIME_W-1:0]       out_dur_q;
	logic signed [bdh_pkg::LVL_W-1:0] out_peak_q;
	logic [bdh_pkg::CNT_W-1:0]        out_cnt_q;
	bdh_pkg::kind_t                   out_kind_q;
	logic                             out_last_q;

	logic                             out_free;
	logic                             step;
	logic                             s1_done;
	logic                             qualify;
	logic                             emit;
	logic                             emit_burst;
	logic                             load;
	logic [bdh_pkg::IDX_W:0]          span_p1;

	assign out_free = !out_valid_q || m_tready;
	assign step     = s1_valid_q && out_free;
	assign qualify  = s1_cand_s1
		&& (width_s1 >= bdh_pkg::WID_W'(cfg.min_w))
		&& (seen_q < bdh_pkg::CNT_W'(bdh_pkg::MAX_PINGS));
	assign span_p1  = {1'b0, q_evt.span} + 1'b1;

	always_comb begin
		s1_done    = 1'b0;
		emit       = 1'b0;
		emit_burst = 1'b0;
		if (step) begin
			if (s1_clr_s1) begin
				s1_done = 1'b1;
				emit    = s1_summ_s1;
			end else if (!phase_q && qualify) begin
				emit       = 1'b1;
				emit_burst = 1'b1;
				s1_done    = !s1_summ_s1;
			end else begin
				s1_done = 1'b1;
				emit    = s1_summ_s1;
			end
		end
		load = !s1_valid_q || s1_done;
		pop  = load && !q_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			phase_q     <= 1'b0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				s1_valid_q <= !q_empty;
			if (s1_done)
				phase_q <= 1'b0;
			else if (step)
				phase_q <= 1'b1;
			if (step && s1_clr_s1)
				seen_q <= '0;
			else if (emit_burst)
				seen_q <= seen_q + 1'b1;
			if (out_free)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_clr_s1     <= q_evt.clr;
			s1_cand_s1    <= q_evt.cand;
			s1_summ_s1    <= q_evt.summ;
			start_time_s1 <= bdh_pkg::TIME_W'(q_evt.start) * bdh_pkg::TIME_W'(cfg.period);
			duration_s1   <= bdh_pkg::TIME_W'(q_evt.span) * bdh_pkg::TIME_W'(cfg.period);
			width_s1      <= bdh_pkg::WID_W'(span_p1) * bdh_pkg::WID_W'(cfg.period);
			peak_s1       <= q_evt.peak;
		end
		if (emit) begin
			if (emit_burst) begin
				out_kind_q  <= bdh_pkg::KIND_BURST;
				out_start_q <= start_time_s1;
				out_dur_q   <= duration_s1;
				out_peak_q  <= peak_s1;
				out_cnt_q   <= seen_q + 1'b1;
				out_last_q  <= !s1_summ_s1;
			end else begin
				out_kind_q  <= bdh_pkg::KIND_SUMMARY;
				out_start_q <= '0;
				out_dur_q   <= '0;
				out_peak_q  <= '0;
				out_cnt_q   <= s1_clr_s1 ? '0 : seen_q;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_peak_q, out_dur_q, out_start_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`include "assert_macros.svh"

	`ASSERT_RST(a_seen_bound, seen_q <= bdh_pkg::CNT_W'(bdh_pkg::MAX_PINGS), "bdh_back: burst count past limit")
	`ASSERT_RST(a_phase_owed, phase_q |-> (s1_valid_q && s1_summ_s1 && !s1_clr_s1), "bdh_back: summary owed without entry")

endmodule

`default_nettype wire

FILE: hdl/burst_detector_hysteresis.sv
// Top level of the hysteresis burst detector: configuration registers, front end,
// entry queue and back end. Depends on bdh_pkg, bdh_front, bdh_fifo and bdh_back.
//
//   channel   beat contents                                       direction
//   s_*       tdata level; tuser first_sample; tlast last_sample   in
//   m_*       tdata times/peak/count; tuser kind; tlast end_of_run out
//   cfg_*     register index and value, written when cfg_we high   in
//
// One sample per cycle while s_tready is high; a sample's entry goes through the queue,
// the product stage and the output register. A last sample that also closes a reported
// burst gives two beats, burst beat first. s_tready drops only while the four-entry queue
// in front of the back end is full: m_tready held low, or many two-beat last samples.
// Reset clears control state, not data registers; loads register defaults; no clearing pass.
`default_nettype none

module burst_detector_hysteresis (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,   // level
	input  wire logic                        s_tuser,   // first_sample
	input  wire logic                        s_tlast,   // last_sample
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [87:0]                      m_tdata,   // start_time, duration, peak_level, burst_count
	output logic                             m_tuser,   // record_kind
	output logic                             m_tlast,   // end_of_run
	input  wire logic                        cfg_we,
	input  wire logic [bdh_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [bdh_pkg::CFG_DW-1:0]  cfg_wdata
);

	bdh_pkg::cfg_t cfg_q;
	bdh_pkg::evt_t push_evt;
	bdh_pkg::evt_t head_evt;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_thr  <= bdh_pkg::ON_THR_RST;
			cfg_q.off_thr <= bdh_pkg::OFF_THR_RST;
			cfg_q.period  <= bdh_pkg::PERIOD_RST;
			cfg_q.min_w   <= bdh_pkg::MIN_W_RST;
		end else if (cfg_we) begin
			case (bdh_pkg::reg_idx_t'(cfg_addr))
				bdh_pkg::REG_ON_THR:  cfg_q.on_thr  <= cfg_wdata[bdh_pkg::LVL_W-1:0];
				bdh_pkg::REG_OFF_THR: cfg_q.off_thr <= cfg_wdata[bdh_pkg::LVL_W-1:0];
				bdh_pkg::REG_PERIOD:  cfg_q.period  <= cfg_wdata[bdh_pkg::PER_W-1:0];
				bdh_pkg::REG_MIN_W:   cfg_q.min_w   <= cfg_wdata[bdh_pkg::MINW_W-1:0];
				default: ;
			endcase
		end
	end

	bdh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.level        (s_tdata),
		.first_sample (s_tuser),
		.last_sample  (s_tlast),
		.q_full       (q_full),
		.push         (push),
		.evt          (push_evt)
	);

	bdh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_evt (push_evt),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rd_evt (head_evt)
	);

	bdh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_evt    (head_evt),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
